// File: rtl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants of the pattern matcher: the command item that
// travels from the front end through the queue to the search engine.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int SYM_W = 8;
  localparam int POS_W = 32;

  // Item kinds, as decoded from mode and starts_new.
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_TEXT     = 2'd1,
    OP_LOAD_NEW = 2'd2,
    OP_TEXT_NEW = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] symbol;
  } cmd_t;

endpackage

// File: rtl/kmp_front.sv
// ----------------------------------------------------------------------------
// kmp_front
// Input stage: accepts stream items, classifies them into commands and holds
// one command until the queue takes it.
// ----------------------------------------------------------------------------
module kmp_front
  import kmp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [SYM_W-1:0] in_tdata,   // symbol
  input  logic [1:0]       in_tuser,   // mode, starts_new
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output cmd_t             cmd
);

  logic valid_r;
  logic valid_nxt;
  cmd_t cmd_r;
  op_t  op_dec;

  assign in_tready = !valid_r || cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    unique case (in_tuser)
      2'b00:   op_dec = OP_LOAD;
      2'b01:   op_dec = OP_TEXT;
      2'b10:   op_dec = OP_LOAD_NEW;
      default: op_dec = OP_TEXT_NEW;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd_ready) begin
      valid_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r.op     <= op_dec;
      cmd_r.symbol <= in_tdata;
    end
  end

endmodule

// File: rtl/kmp_queue.sv
// ----------------------------------------------------------------------------
// kmp_queue
// Two-entry command queue between the front end and the search engine.
// ----------------------------------------------------------------------------
module kmp_queue
  import kmp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// File: rtl/kmp_engine.sv
// ----------------------------------------------------------------------------
// kmp_engine
// Search engine: holds the pattern and its failure table in memories,
// extends the table for pattern bytes and walks the match for text bytes.
// ----------------------------------------------------------------------------
module kmp_engine
  import kmp_pkg::*;
#(
  parameter int PATTERN_MAX = 512
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [POS_W-1:0] out_tdata
);

  localparam int LW  = $clog2(PATTERN_MAX + 1);
  localparam int SAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [LW-1:0] LEN_MAX = LW'(PATTERN_MAX);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_FAIL
  } state_t;

  state_t           st_r, st_nxt;
  logic [LW-1:0]    j_r, j_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic             text_r, text_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [LW-1:0]    bpi_r, bpi_nxt;
  logic [LW-1:0]    mi_r, mi_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_data_r, out_data_nxt;

  // Pattern store and failure table, one write and one read port each.
  logic [SYM_W-1:0] pstore [PATTERN_MAX];
  logic [LW-1:0]    ftab   [PATTERN_MAX + 1];
  logic [SYM_W-1:0] ps_rdata_r;
  logic [LW-1:0]    ft_rdata_r;
  logic             ps_we, ft_we;
  logic [SAW-1:0]   ps_waddr, ps_raddr;
  logic [SYM_W-1:0] ps_wdata;
  logic [LW-1:0]    ft_waddr, ft_raddr, ft_wdata;

  logic             hit;
  logic [LW-1:0]    j_adv;
  logic             out_busy;

  always_ff @(posedge clk) begin
    if (ps_we) begin
      pstore[ps_waddr] <= ps_wdata;
    end
    ps_rdata_r <= pstore[ps_raddr];
  end

  always_ff @(posedge clk) begin
    if (ft_we) begin
      ftab[ft_waddr] <= ft_wdata;
    end
    ft_rdata_r <= ftab[ft_raddr];
  end

  assign cmd_ready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_busy   = out_valid_r && !out_tready;
  assign hit        = (ps_rdata_r == sym_r);
  assign j_adv      = hit ? (j_r + LW'(1)) : j_r;

  always_comb begin
    st_nxt        = st_r;
    j_nxt         = j_r;
    sym_nxt       = sym_r;
    text_nxt      = text_r;
    len_nxt       = len_r;
    bpi_nxt       = bpi_r;
    mi_nxt        = mi_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_busy;
    out_data_nxt  = out_data_r;
    ps_we         = 1'b0;
    ps_waddr      = len_r[SAW-1:0];
    ps_wdata      = sym_r;
    ps_raddr      = j_r[SAW-1:0];
    ft_we         = 1'b0;
    ft_waddr      = len_r + LW'(1);
    ft_wdata      = j_adv;
    ft_raddr      = j_r;

    unique case (st_r)
      S_IDLE: begin
        if (cmd_valid) begin
          sym_nxt = cmd.symbol;
          unique case (cmd.op)
            OP_LOAD_NEW, OP_LOAD: begin
              text_nxt = 1'b0;
              if (cmd.op == OP_LOAD_NEW || len_r == '0) begin
                // First pattern byte: its border is empty.
                if (cmd.op == OP_LOAD_NEW) begin
                  mi_nxt  = '0;
                  pos_nxt = '0;
                end
                ps_we    = 1'b1;
                ps_waddr = '0;
                ps_wdata = cmd.symbol;
                ft_we    = 1'b1;
                ft_waddr = LW'(1);
                ft_wdata = '0;
                bpi_nxt  = '0;
                len_nxt  = LW'(1);
              end else if (len_r != LEN_MAX) begin
                j_nxt    = bpi_r;
                ps_raddr = bpi_r[SAW-1:0];
                st_nxt   = S_CMP;
              end
            end
            default: begin
              text_nxt = 1'b1;
              if (len_r == '0) begin
                pos_nxt = (cmd.op == OP_TEXT_NEW) ? POS_W'(1) : pos_r + POS_W'(1);
              end else if (cmd.op == OP_TEXT_NEW) begin
                pos_nxt  = '0;
                j_nxt    = '0;
                ps_raddr = '0;
                st_nxt   = S_CMP;
              end else begin
                j_nxt    = mi_r;
                ps_raddr = mi_r[SAW-1:0];
                st_nxt   = S_CMP;
              end
            end
          endcase
        end
      end

      S_CMP: begin
        if (!hit && j_r != '0) begin
          // Mismatch: fetch the border of the current prefix.
          ft_raddr = j_r;
          st_nxt   = S_FAIL;
        end else if (!text_r) begin
          ps_we   = 1'b1;
          ft_we   = 1'b1;
          bpi_nxt = j_adv;
          len_nxt = len_r + LW'(1);
          st_nxt  = S_IDLE;
        end else if (j_adv == len_r) begin
          // Full occurrence; the border of the whole pattern is bpi_r.
          if (!out_busy) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = pos_r - POS_W'(len_r - LW'(1));
            mi_nxt        = bpi_r;
            pos_nxt       = pos_r + POS_W'(1);
            st_nxt        = S_IDLE;
          end
        end else begin
          mi_nxt  = j_adv;
          pos_nxt = pos_r + POS_W'(1);
          st_nxt  = S_IDLE;
        end
      end

      default: begin
        j_nxt    = ft_rdata_r;
        ps_raddr = ft_rdata_r[SAW-1:0];
        st_nxt   = S_CMP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      len_r       <= '0;
      bpi_r       <= '0;
      mi_r        <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      len_r       <= len_nxt;
      bpi_r       <= bpi_nxt;
      mi_r        <= mi_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    sym_r      <= sym_nxt;
    text_r     <= text_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: rtl/kmp_pattern_matcher.sv
// ----------------------------------------------------------------------------
// kmp_pattern_matcher
// Streaming Knuth-Morris-Pratt search over a loaded byte pattern.
// ----------------------------------------------------------------------------
// Load a pattern with items of mode 0 (starts_new on the first byte), then
// send text with items of mode 1 (starts_new on the first byte of a text).
// Each full occurrence, overlapping ones included, yields one item carrying
// the text offset of its first byte, modulo 2^32. Pattern bytes beyond
// PATTERN_MAX are dropped and an empty pattern never matches. A pattern or
// text byte passes from S_IDLE through S_CMP in the engine, plus S_FAIL
// and S_CMP again per failure-table step, since each step is a registered
// read of the failure table followed by a registered read of the pattern
// store. Dropped pattern bytes, the first byte of a pattern and text bytes
// against an empty pattern are done in S_IDLE alone. A two-entry queue and
// an input register let the input keep flowing while the engine works or a
// result waits. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher
  import kmp_pkg::*;
#(
  parameter int PATTERN_MAX = 512
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,    // [7:0] symbol
  input  logic [1:0]       in_tuser,    // [0] mode, [1] starts_new
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [POS_W-1:0] out_tdata    // [31:0] match_position
);

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  kmp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  kmp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_cmd   (fr_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  kmp_engine #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: verif/tb_kmp_pattern_matcher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kmp_pattern_matcher
// Self-checking bench for the streaming pattern matcher. A queue of pattern
// and text bytes is built up front: a directed part, then random patterns
// over small alphabets followed by text that often repeats them, mixed with
// short runs of random items. A predictor tracks the pattern, its border
// table and the match progress, and queues each expected match offset; the
// monitor checks every result against the oldest one.
// ----------------------------------------------------------------------------
module tb_kmp_pattern_matcher;
  import kmp_pkg::*;

  localparam int PATTERN_MAX = 512;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    op_t        op;
    logic [7:0] sym;
    logic       drain;
  } stim_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;    // [7:0] symbol
  logic [1:0]       in_tuser = '0;    // [0] mode, [1] starts_new
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [POS_W-1:0] out_tdata;        // [31:0] match_position

  stim_t            pending[$];
  logic [POS_W-1:0] match_q[$];
  logic             next_drain = 1'b0;

  // Predictor state.
  logic [7:0]       pat_mem[PATTERN_MAX];
  int unsigned      border_tbl[PATTERN_MAX+1];
  int unsigned      pat_len = 0;
  int unsigned      build_border = 0;
  int unsigned      match_len = 0;
  logic [POS_W-1:0] text_pos = '0;

  logic             in_acc = 1'b0;
  int               in_count = 0;
  int               hold_at = 0;
  int               hold_left = 0;
  logic             held = 1'b0;
  int               idle_cnt = 0;
  int               errors = 0;
  logic             quiet;

  kmp_pattern_matcher #(.PATTERN_MAX(PATTERN_MAX)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  assign quiet = (in_count >= hold_at + 100) && (in_count < hold_at + 250);

  function automatic int unsigned follow_borders(int unsigned j, logic [7:0] c);
    while (j > 0 && j < PATTERN_MAX && pat_mem[j] != c) begin
      j = border_tbl[j];
    end
    return j;
  endfunction

  task automatic predict_item(input op_t op, input logic [7:0] c);
    int unsigned len;
    int unsigned j;
    if (op == OP_LOAD || op == OP_LOAD_NEW) begin
      if (op == OP_LOAD_NEW) begin
        pat_len = 0;
        build_border = 0;
        match_len = 0;
        text_pos = '0;
      end
      len = pat_len;
      if (len < PATTERN_MAX) begin
        j = 0;
        if (len > 0) begin
          j = follow_borders(build_border, c);
          if (j < len && pat_mem[j] == c) j++;
        end
        pat_mem[len] = c;
        border_tbl[len+1] = j;
        build_border = j;
        pat_len = len + 1;
      end
    end else begin
      if (op == OP_TEXT_NEW) begin
        match_len = 0;
        text_pos = '0;
      end
      len = pat_len;
      if (len > 0) begin
        j = match_len;
        if (j >= len) j = border_tbl[len];
        j = follow_borders(j, c);
        if (j < len && pat_mem[j] == c) j++;
        // A full match reports its start and keeps the border for overlaps.
        if (j == len) begin
          match_q.push_back(text_pos - POS_W'(len - 1));
          j = border_tbl[len];
        end
        match_len = j;
      end
      text_pos = text_pos + 1'b1;
    end
  endtask

  task automatic add(input op_t op, input logic [7:0] sym);
    stim_t it;
    it.op = op;
    it.sym = sym;
    it.drain = next_drain;
    next_drain = 1'b0;
    pending.push_back(it);
  endtask

  function automatic logic [7:0] pick(logic [7:0] a0, logic [7:0] a1);
    return ($urandom_range(0, 2) == 0) ? a1 : a0;
  endfunction

  // Driver: present the next item once the current one has been taken.
  always @(negedge clk) begin : drive
    stim_t it;
    logic  busy;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      busy = in_tvalid && !in_acc;
      if (!busy) begin
        if (pending.size() != 0 && (quiet || $urandom_range(0, 99) >= 10) &&
            !(pending[0].drain && match_q.size() != 0)) begin
          it = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= it.sym;
          in_tuser  <= it.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off that backs up the input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!held && in_count >= hold_at) begin
        held <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end
      out_tready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 10);
    end
  end

  // Monitor: predict on each accepted input, check each accepted result.
  always @(posedge clk) begin : monitor
    logic [POS_W-1:0] want;
    in_acc <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_item(op_t'(in_tuser), in_tdata);
        in_count <= in_count + 1;
      end
      if (out_tvalid && out_tready) begin
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d", $time, out_tdata);
          errors <= errors + 1;
        end else begin
          want = match_q.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: match_position mismatch, expected %0d, got %0d",
                     $time, want, out_tdata);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_cnt);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    logic [7:0] a0;
    logic [7:0] a1;
    logic [7:0] b;
    logic [7:0] pat_copy[$];
    op_t        op;
    int         plen;
    int         tlen;
    int         k;
    int         m;
    int         n;
    int         rnd_base;

    // Text against an empty pattern, then a pattern begun without starts_new.
    add(OP_TEXT_NEW, 8'h00);
    add(OP_TEXT, 8'hFF);
    add(OP_LOAD, 8'hFF);
    add(OP_TEXT, 8'hFF);
    add(OP_TEXT, 8'h00);
    // Overlapping occurrences of "aba".
    add(OP_LOAD_NEW, 8'h61);
    add(OP_LOAD, 8'h62);
    add(OP_LOAD, 8'h61);
    add(OP_TEXT_NEW, 8'h61);
    add(OP_TEXT, 8'h62);
    add(OP_TEXT, 8'h61);
    add(OP_TEXT, 8'h62);
    add(OP_TEXT, 8'h61);
    // The pattern grows in the middle of a text and keeps its progress.
    add(OP_LOAD, 8'h62);
    add(OP_TEXT, 8'h62);
    add(OP_TEXT_NEW, 8'h61);
    add(OP_TEXT, 8'h62);
    add(OP_TEXT, 8'h61);
    add(OP_TEXT, 8'h62);
    // Extreme byte values.
    add(OP_LOAD_NEW, 8'h00);
    add(OP_LOAD, 8'hFF);
    add(OP_TEXT_NEW, 8'h00);
    add(OP_TEXT, 8'hFF);
    add(OP_TEXT, 8'h00);
    add(OP_TEXT, 8'hFF);

    // Random part: the first item waits until all matches so far are out.
    rnd_base = pending.size();
    hold_at = rnd_base + 60;
    next_drain = 1'b1;
    while (pending.size() - rnd_base < 375) begin
      if ($urandom_range(0, 99) < 80) begin
        a0 = 8'($urandom_range(0, 255));
        a1 = ($urandom_range(0, 3) == 0) ? ~a0 : 8'($urandom_range(0, 255));
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
        pat_copy.delete();
        for (k = 0; k < plen; k++) begin
          b = pick(a0, a1);
          pat_copy.push_back(b);
          add((k == 0 && $urandom_range(0, 9) != 0) ? OP_LOAD_NEW : OP_LOAD, b);
        end
        tlen = $urandom_range(8, 40);
        k = 0;
        while (k < tlen) begin
          op = (k == 0 && $urandom_range(0, 7) != 0) ? OP_TEXT_NEW : OP_TEXT;
          if ($urandom_range(0, 3) == 0) begin
            for (m = 0; m < pat_copy.size(); m++) begin
              add((m == 0) ? op : OP_TEXT, pat_copy[m]);
            end
            k += pat_copy.size();
          end else if (k > 0 && $urandom_range(0, 39) == 0) begin
            b = pick(a0, a1);
            pat_copy.push_back(b);
            add(OP_LOAD, b);
            k++;
          end else begin
            add(op, pick(a0, a1));
            k++;
          end
        end
      end else begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) add(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending.size() != 0 || in_tvalid) @(posedge clk);
    while (match_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (match_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, match_q.size());
      errors = errors + 1;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/kmp_pkg.sv
rtl/kmp_front.sv
rtl/kmp_queue.sv
rtl/kmp_engine.sv
rtl/kmp_pattern_matcher.sv
verif/tb_kmp_pattern_matcher.sv
